/* hw/rtl/aabbobb_pkg.sv */
// Package with shared types, constants and sequencer states for the box overlap tester.
package aabbobb_pkg;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NUM_SLOTS       = 21;
    localparam int SLOT_W          = 5;
    localparam int EPS_W           = 8;
    localparam logic [EPS_W-1:0] EPS_RESET = 8'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_MUL,
        ST_CHECK
    } t_state;
endpackage

/* hw/rtl/aabbobb_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module aabbobb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 21
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hw/rtl/aabbobb_axis.sv */
// Shared axis unit: one product per cycle while i_mul_en is high, accumulated into radius and distance sums.
module aabbobb_axis #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_clr,
    input  logic                   i_mul_en,
    input  logic                   i_to_r,
    input  logic                   i_neg,
    input  logic signed [VALUE_WIDTH+1:0] i_a,
    input  logic signed [VALUE_WIDTH+1:0] i_b,
    output logic                   o_sep
);
    localparam int PW = 2 * VALUE_WIDTH + 4;
    localparam int AW = PW + 4;

    logic signed [PW-1:0] r_prod;
    logic                 r_to_r;
    logic                 r_neg;
    logic                 r_vld;
    logic signed [AW-1:0] r_r;
    logic signed [AW-1:0] r_d;
    logic signed [AW-1:0] w_term;
    logic signed [AW-1:0] w_absd;

    always_ff @(posedge i_clk) begin
        r_prod <= PW'(i_a * i_b);
        r_to_r <= i_to_r;
        r_neg  <= i_neg;
        r_vld  <= i_mul_en;
        if (i_clr) begin
            r_r <= '0;
            r_d <= '0;
        end else if (r_vld) begin
            if (r_to_r) begin
                r_r <= r_r + w_term;
            end else begin
                r_d <= r_d + w_term;
            end
        end
    end

    always_comb begin
        w_term = r_neg ? -AW'(r_prod) : AW'(r_prod);
        w_absd = r_d[AW-1] ? -r_d : r_d;
        o_sep  = w_absd > r_r;
    end
endmodule

/* hw/rtl/aabb_obb_overlap_test_top.sv */
// Top level of the AABB/OBB separating axis overlap tester.
// Loads: a request without last is written at its accept edge and busy stays low.
// A request with last copies the store into the operand file, then tests the A, B and cross
// axes in turn on one shared multiplier, stopping at the first separating axis, then strobes.
// Throughput: one operand load per cycle while busy is low; the receiver cannot stall results.
// Reset: synchronous, active low; a clearing pass zeroes all 21 slots of the operand store.
module aabb_obb_overlap_test_top
    import aabbobb_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [aabbobb_pkg::SLOT_W-1:0] i_slot,
    input  logic signed [31:0]            i_value,
    input  logic                          i_last,
    input  logic                          i_eps_we,
    input  logic [aabbobb_pkg::EPS_W-1:0] i_eps_wdata,
    output logic                          o_valid,
    output logic                          o_overlap
);
    // Operand widths inside the datapath: one extra bit for differences and
    // the epsilon-padded absolute values, one more for sign.
    localparam int OW = VALUE_WIDTH + 2;
    // Per axis: 4 radius products and up to 3 distance products.
    localparam int NPROD = 7;

    typedef logic signed [OW-1:0] t_op;

    t_state              r_state, n_state;
    logic [SLOT_W-1:0]   r_cnt, n_cnt;       // clear address / load address
    logic [3:0]          r_axis, n_axis;
    logic [2:0]          r_step, n_step;
    logic [EPS_W-1:0]    r_eps;
    logic                r_pend, n_pend;     // a load of the store is pending
    logic                r_vld, n_vld;
    logic                r_ovl, n_ovl;

    // Operand file gathered from the store for the test. The RAM holds the
    // state; this register bank is the working copy for one test run.
    t_op                 r_opnd [NUM_SLOTS];

    logic                w_we;
    logic [SLOT_W-1:0]   w_waddr;
    logic [VALUE_WIDTH-1:0] w_wdata;
    logic [VALUE_WIDTH-1:0] w_rdata;
    logic [SLOT_W-1:0]   r_rd_addr;
    logic                r_rd_vld;

    logic                w_clr, w_mul_en, w_to_r, w_neg, w_sep;
    t_op                 w_a, w_b;

    aabbobb_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(NUM_SLOTS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_cnt),
        .o_rdata(w_rdata)
    );

    aabbobb_axis #(.VALUE_WIDTH(VALUE_WIDTH)) u_axis (
        .i_clk   (i_clk),
        .i_clr   (w_clr),
        .i_mul_en(w_mul_en),
        .i_to_r  (w_to_r),
        .i_neg   (w_neg),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_sep   (w_sep)
    );

    // Operand helpers: t = obb center - aabb center, e_a, e_b, rotation.
    function automatic t_op f_t(input t_op o [NUM_SLOTS], input int i);
        return o[6 + i] - o[i];
    endfunction

    function automatic t_op f_rot(input t_op o [NUM_SLOTS], input int i, input int j);
        return o[9 + 3 * j + i];
    endfunction

    function automatic t_op f_arot(input t_op o [NUM_SLOTS], input int i, input int j,
                                   input logic [EPS_W-1:0] e);
        t_op c;
        c = o[9 + 3 * j + i];
        return (c < 0 ? -c : c) + t_op'(e);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
            r_axis  <= '0;
            r_step  <= '0;
            r_eps   <= EPS_RESET;
            r_pend  <= 1'b0;
            r_vld   <= 1'b0;
            r_ovl   <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
            r_step  <= n_step;
            r_pend  <= n_pend;
            r_vld   <= n_vld;
            r_ovl   <= n_ovl;
            r_rd_vld <= (r_state == ST_LOAD);
            if (i_eps_we) begin
                r_eps <= i_eps_wdata;
            end
        end
        r_rd_addr <= r_cnt;
        if (r_rd_vld) begin
            r_opnd[r_rd_addr] <= OW'($signed(w_rdata));
        end
    end

    // Select the two factors of the current product of the current axis.
    always_comb begin
        int i, j, i1, i2, j1, j2;
        t_op one;
        one    = t_op'(1) <<< FRAC_BITS;
        w_a    = '0;
        w_b    = '0;
        w_to_r = 1'b1;
        w_neg  = 1'b0;
        i = 0; j = 0; i1 = 0; i2 = 0; j1 = 0; j2 = 0;
        if (r_axis < 4'd3) begin
            i = int'(r_axis);
            case (r_step)
                3'd0: begin w_a = r_opnd[3 + i]; w_b = one; end
                3'd1, 3'd2, 3'd3: begin
                    w_a = r_opnd[18 + int'(r_step) - 1];
                    w_b = f_arot(r_opnd, i, int'(r_step) - 1, r_eps);
                end
                3'd4: begin w_a = f_t(r_opnd, i); w_b = one; w_to_r = 1'b0; end
                default: ;
            endcase
        end else if (r_axis < 4'd6) begin
            j = int'(r_axis) - 3;
            case (r_step)
                3'd0: begin w_a = r_opnd[18 + j]; w_b = one; end
                3'd1, 3'd2, 3'd3: begin
                    w_a = r_opnd[3 + int'(r_step) - 1];
                    w_b = f_arot(r_opnd, int'(r_step) - 1, j, r_eps);
                end
                3'd4, 3'd5, 3'd6: begin
                    w_a = f_t(r_opnd, int'(r_step) - 4);
                    w_b = f_rot(r_opnd, int'(r_step) - 4, j);
                    w_to_r = 1'b0;
                end
                default: ;
            endcase
        end else begin
            // Cross axes run through the A axis i outer and the B axis j inner.
            case (r_axis)
                4'd6, 4'd7, 4'd8:   i = 0;
                4'd9, 4'd10, 4'd11: i = 1;
                default:            i = 2;
            endcase
            j  = int'(r_axis) - 6 - 3 * i;
            i1 = (i == 2) ? 0 : i + 1;
            i2 = (i == 0) ? 2 : i - 1;
            j1 = (j == 2) ? 0 : j + 1;
            j2 = (j == 0) ? 2 : j - 1;
            case (r_step)
                3'd0: begin w_a = r_opnd[3 + i1]; w_b = f_arot(r_opnd, i2, j, r_eps); end
                3'd1: begin w_a = r_opnd[3 + i2]; w_b = f_arot(r_opnd, i1, j, r_eps); end
                3'd2: begin w_a = r_opnd[18 + j1]; w_b = f_arot(r_opnd, i, j2, r_eps); end
                3'd3: begin w_a = r_opnd[18 + j2]; w_b = f_arot(r_opnd, i, j1, r_eps); end
                3'd4: begin
                    w_a = f_t(r_opnd, i2); w_b = f_rot(r_opnd, i1, j); w_to_r = 1'b0;
                end
                3'd5: begin
                    w_a = f_t(r_opnd, i1); w_b = f_rot(r_opnd, i2, j);
                    w_to_r = 1'b0; w_neg = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Sequencer: clear pass, idle write, store read-out, products, check.
    always_comb begin
        logic [2:0] last_step;
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_axis   = r_axis;
        n_step   = r_step;
        n_pend   = r_pend;
        n_vld    = 1'b0;
        n_ovl    = r_ovl;
        w_we     = 1'b0;
        w_waddr  = r_cnt;
        w_wdata  = '0;
        w_clr    = 1'b0;
        w_mul_en = 1'b0;
        busy     = 1'b1;
        last_step = (r_axis < 4'd3) ? 3'd4 : 3'(NPROD - 1);
        if (r_axis >= 4'd6) last_step = 3'd5;
        case (r_state)
            ST_CLEAR: begin
                w_we = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SLOT_W'(NUM_SLOTS - 1)) begin
                    n_cnt = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    w_waddr = i_slot;
                    w_wdata = i_value[VALUE_WIDTH-1:0];
                    w_we    = (i_slot < SLOT_W'(NUM_SLOTS));
                    if (i_last) begin
                        n_state = ST_LOAD;
                        n_cnt   = '0;
                    end
                end
            end
            ST_LOAD: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == SLOT_W'(NUM_SLOTS - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_MUL;
                    n_axis  = '0;
                    n_step  = '0;
                    w_clr   = 1'b1;
                    n_pend  = 1'b1;
                end
            end
            ST_MUL: begin
                // First cycle waits for the last operand to land.
                if (r_pend) begin
                    n_pend = 1'b0;
                    w_clr  = 1'b1;
                end else begin
                    w_mul_en = 1'b1;
                    n_step   = r_step + 1'b1;
                    if (r_step == last_step) begin
                        n_step  = '0;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // The last product reaches the accumulator, then the comparison settles
                // and is taken on the final check step.
                n_step = r_step + 1'b1;
                if (r_step == 3'd2) begin
                    n_step = '0;
                    if (w_sep || r_axis == 4'd14) begin
                        n_vld   = 1'b1;
                        n_ovl   = !w_sep;
                        n_state = ST_IDLE;
                        n_axis  = '0;
                    end else begin
                        n_axis  = r_axis + 1'b1;
                        w_clr   = 1'b1;
                        n_state = ST_MUL;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_valid   = r_vld;
    assign o_overlap = r_ovl;
endmodule

/* hw/rtl/aabbobb_chk.sv */
// Port-level checker for the box overlap tester, bound to the top level.
module aabbobb_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_last,
    input logic o_valid
);
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last) |=> !busy)
        else $error("plain load left the block busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> busy)
        else $error("test request did not start a run");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");
endmodule

bind aabb_obb_overlap_test_top aabbobb_chk u_chk (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .start  (start),
    .busy   (busy),
    .i_last (i_last),
    .o_valid(o_valid)
);
